// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the checker files.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under reset
`define AM_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication under reset
`define AM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- rtl/lrha_pkg.sv -----
// Shared types, codes and helpers of the low-rank Hebbian adapter.
// Used by lrha_ctrl, lrha_dpath and the top level; depends on nothing.
package lrha_pkg;

   localparam int DIM_DEF  = 48;
   localparam int RANK_DEF = 4;

   localparam logic [30:0] GAIN_RST  = 31'd644245;
   localparam logic [31:0] DECAY_RST = 32'd2147268900;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY = 1'b1;

   typedef enum logic [1:0] {
      REQ_LOAD_A = 2'd0,
      REQ_LOAD_B = 2'd1,
      REQ_APPLY  = 2'd2,
      REQ_UPDATE = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      PH_PROJ_B,
      PH_UPD_A,
      PH_PROJ_A,
      PH_UPD_B,
      PH_DECAY_A,
      PH_DECAY_B,
      PH_OUT
   } phase_type;

   typedef enum logic [2:0] {
      SUB_READ,
      SUB_MUL1,
      SUB_SHIFT,
      SUB_MUL2,
      SUB_WRITE
   } sub_type;

   typedef struct packed {
      phase_type phase;
      sub_type   sub;
      logic      exec;
      logic      fin;
      logic      clr;
   } cmd_type;

   typedef struct packed {
      logic decay_en;
   } status_type;

   function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
      logic signed [31:0] res;
      if (v > 48'sd2147483647) begin
         res = 32'sh7fffffff;
      end else if (v < -48'sd2147483648) begin
         res = 32'sh80000000;
      end else begin
         res = v[31:0];
      end
      return res;
   endfunction

endpackage

// ----- rtl/low_rank_hebbian_adapter.sv -----
// Channel   Dir  Handshake              Payload
// req       in   req_tvalid/req_tready  tdata index,x,operand; tuser kind; tlast
// rsp       out  rsp_tvalid/rsp_tready  tdata out_value,out_index; tlast
// csr       in   csr_we                 csr_index, csr_wdata
// Loads and element beats are taken while the sequencer is idle. One shared multiplier
// does all work; each multiply-add steps through read, multiply, shift, multiply and write.
// Apply runs a projection and then one result per element; update runs two projections and
// two updates, plus a decay pass over A and B when decay is active. After reset a clearing
// pass zeroes A and B before the first beat is taken. A stalled result holds the sequencer.
module low_rank_hebbian_adapter #(
   parameter int DIM  = lrha_pkg::DIM_DEF,
   parameter int RANK = lrha_pkg::RANK_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [71:0]                    req_tdata,  // index[7:0], x_value, operand_value
   input  logic [1:0]                     req_tuser,  // req_type
   input  logic                           req_tlast,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [39:0]                    rsp_tdata,  // out_value, out_index, zero fill
   output logic                           rsp_tlast,
   input  logic                           csr_we,
   input  logic [lrha_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                    csr_wdata
);

   localparam int IW = $clog2(DIM);
   localparam int RW = (RANK > 1) ? $clog2(RANK) : 1;

   lrha_pkg::cmd_type    cmd;
   lrha_pkg::status_type status;
   logic [IW-1:0]        cnt_i;
   logic [RW-1:0]        cnt_r;
   logic signed [31:0]   out_value;
   logic [5:0]           out_index;

   lrha_ctrl #(.DIM(DIM), .RANK(RANK), .IW(IW), .RW(RW)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_kind   (req_tuser),
      .req_last   (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd),
      .cnt_i      (cnt_i),
      .cnt_r      (cnt_r)
   );

   lrha_dpath #(.DIM(DIM), .RANK(RANK), .IW(IW), .RW(RW)) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_accept  (req_tvalid && req_tready),
      .req_kind    (req_tuser),
      .req_index   (req_tdata[7:0]),
      .req_x       (req_tdata[39:8]),
      .req_operand (req_tdata[71:40]),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .cnt_i       (cnt_i),
      .cnt_r       (cnt_r),
      .status      (status),
      .out_value   (out_value),
      .out_index   (out_index),
      .out_last    (rsp_tlast)
   );

   assign rsp_tdata = {2'b00, out_index, out_value};

endmodule

// ----- rtl/lrha_ctrl.sv -----
// Sequencer of the adapter: clearing sweep, phase walk, result handshake.
// Depends on lrha_pkg; drives lrha_dpath through a command struct.
module lrha_ctrl #(
   parameter int DIM  = lrha_pkg::DIM_DEF,
   parameter int RANK = lrha_pkg::RANK_DEF,
   parameter int IW   = $clog2(DIM),
   parameter int RW   = (RANK > 1) ? $clog2(RANK) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic [1:0]           req_kind,
   input  logic                 req_last,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  lrha_pkg::status_type status,
   output lrha_pkg::cmd_type    cmd,
   output logic [IW-1:0]        cnt_i,
   output logic [RW-1:0]        cnt_r
);

   typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_STEP, ST_FIN, ST_EMIT} state_type;

   state_type           state_ff;
   lrha_pkg::phase_type phase_ff;
   lrha_pkg::sub_type   sub_ff;
   lrha_pkg::sub_type   sub_in;
   logic [IW-1:0]       i_ff, i_in;
   logic [RW-1:0]       r_ff, r_in;
   logic                upd_ff;
   logic                rsp_valid_ff;
   logic                inner_r, i_last, r_last, done, is_sum, inner_wrap, ph_end;
   lrha_pkg::phase_type ph_next;

   always_comb begin
      inner_r = (phase_ff == lrha_pkg::PH_UPD_A) || (phase_ff == lrha_pkg::PH_OUT);
      i_last  = (i_ff == IW'(DIM - 1));
      r_last  = (r_ff == RW'(RANK - 1));
      done    = i_last && r_last;
      inner_wrap = inner_r ? r_last : i_last;
      is_sum  = (phase_ff == lrha_pkg::PH_PROJ_B) || (phase_ff == lrha_pkg::PH_PROJ_A) ||
                (phase_ff == lrha_pkg::PH_OUT);
      if (inner_r) begin
         r_in = r_last ? '0 : r_ff + 1'b1;
         i_in = r_last ? (i_last ? '0 : i_ff + 1'b1) : i_ff;
      end else begin
         i_in = i_last ? '0 : i_ff + 1'b1;
         r_in = i_last ? (r_last ? '0 : r_ff + 1'b1) : r_ff;
      end
      ph_end  = 1'b0;
      ph_next = lrha_pkg::PH_OUT;
      case (phase_ff)
         lrha_pkg::PH_PROJ_B:  ph_next = lrha_pkg::PH_UPD_A;
         lrha_pkg::PH_UPD_A:   ph_next = lrha_pkg::PH_PROJ_A;
         lrha_pkg::PH_PROJ_A:  ph_next = upd_ff ? lrha_pkg::PH_UPD_B : lrha_pkg::PH_OUT;
         lrha_pkg::PH_UPD_B: begin
            ph_next = lrha_pkg::PH_DECAY_A;
            ph_end  = !status.decay_en;
         end
         lrha_pkg::PH_DECAY_A: ph_next = lrha_pkg::PH_DECAY_B;
         default:              ph_end  = 1'b1;
      endcase
      case (sub_ff)
         lrha_pkg::SUB_READ:  sub_in = lrha_pkg::SUB_MUL1;
         lrha_pkg::SUB_MUL1:  sub_in = lrha_pkg::SUB_SHIFT;
         lrha_pkg::SUB_SHIFT: sub_in = lrha_pkg::SUB_MUL2;
         lrha_pkg::SUB_MUL2:  sub_in = lrha_pkg::SUB_WRITE;
         default:             sub_in = lrha_pkg::SUB_READ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         phase_ff     <= lrha_pkg::PH_DECAY_A;
         sub_ff       <= lrha_pkg::SUB_READ;
         i_ff         <= '0;
         r_ff         <= '0;
         upd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_CLEAR: begin
               i_ff <= i_in;
               r_ff <= r_in;
               if (done) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_tvalid && req_last &&
                   ((req_kind == lrha_pkg::REQ_APPLY) || (req_kind == lrha_pkg::REQ_UPDATE))) begin
                  upd_ff   <= (req_kind == lrha_pkg::REQ_UPDATE);
                  phase_ff <= (req_kind == lrha_pkg::REQ_UPDATE) ? lrha_pkg::PH_PROJ_B
                                                                 : lrha_pkg::PH_PROJ_A;
                  i_ff     <= '0;
                  r_ff     <= '0;
                  sub_ff   <= lrha_pkg::SUB_READ;
                  state_ff <= ST_STEP;
               end
            end
            ST_STEP: begin
               sub_ff <= sub_in;
               if (sub_ff == lrha_pkg::SUB_WRITE) begin
                  if (is_sum && inner_wrap) begin
                     state_ff <= ST_FIN;
                  end else begin
                     i_ff <= i_in;
                     r_ff <= r_in;
                     if (done && ph_end) begin
                        state_ff <= ST_IDLE;
                     end else if (done) begin
                        phase_ff <= ph_next;
                     end
                  end
               end
            end
            ST_FIN: begin
               if (phase_ff == lrha_pkg::PH_OUT) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_EMIT;
               end else begin
                  i_ff   <= i_in;
                  r_ff   <= r_in;
                  sub_ff <= lrha_pkg::SUB_READ;
                  state_ff <= ST_STEP;
                  if (done && ph_end) begin
                     state_ff <= ST_IDLE;
                  end else if (done) begin
                     phase_ff <= ph_next;
                  end
               end
            end
            ST_EMIT: begin
               if (rsp_tready) begin
                  rsp_valid_ff <= 1'b0;
                  i_ff   <= i_in;
                  r_ff   <= r_in;
                  sub_ff <= lrha_pkg::SUB_READ;
                  state_ff <= done ? ST_IDLE : ST_STEP;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign cnt_i      = i_ff;
   assign cnt_r      = r_ff;
   assign cmd.phase  = phase_ff;
   assign cmd.sub    = sub_ff;
   assign cmd.exec   = (state_ff == ST_STEP);
   assign cmd.fin    = (state_ff == ST_FIN);
   assign cmd.clr    = (state_ff == ST_CLEAR);

endmodule

// ----- rtl/lrha_dpath.sv -----
// Datapath of the adapter: A, B, x and operand stores, shared multiplier,
// accumulator, projection registers, settings and result register. Uses lrha_pkg.
module lrha_dpath #(
   parameter int DIM  = lrha_pkg::DIM_DEF,
   parameter int RANK = lrha_pkg::RANK_DEF,
   parameter int IW   = $clog2(DIM),
   parameter int RW   = (RANK > 1) ? $clog2(RANK) : 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_accept,
   input  logic [1:0]                        req_kind,
   input  logic [7:0]                        req_index,
   input  logic signed [31:0]                req_x,
   input  logic signed [31:0]                req_operand,
   input  logic                              csr_we,
   input  logic [lrha_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [31:0]                       csr_wdata,
   input  lrha_pkg::cmd_type                 cmd,
   input  logic [IW-1:0]                     cnt_i,
   input  logic [RW-1:0]                     cnt_r,
   output lrha_pkg::status_type              status,
   output logic signed [31:0]                out_value,
   output logic [5:0]                        out_index,
   output logic                              out_last
);

   localparam int NENT = DIM * RANK;
   localparam int AW   = $clog2(NENT);

   logic signed [31:0] mem_a [NENT];
   logic signed [31:0] mem_b [NENT];
   logic signed [31:0] mem_x [DIM];
   logic signed [31:0] mem_op [DIM];
   logic signed [31:0] rd_a_ff, rd_b_ff, rd_x_ff, rd_op_ff;
   logic signed [31:0] proj_ff [RANK];

   logic [30:0]        gain_ff;
   logic [31:0]        decay_ff;
   logic signed [65:0] prod_ff;
   logic signed [37:0] shift_ff, shift_in;
   logic signed [47:0] acc_ff;
   logic signed [31:0] out_value_ff;
   logic [5:0]         out_index_ff;
   logic               out_last_ff;

   logic [AW-1:0]      addr_a, addr_b, wa_a, wa_b;
   logic               we_a, we_b, load_ok, elem_ok, shift31, step, sum_ph;
   logic signed [31:0] wd_a, wd_b, gx, proj_r;
   logic signed [32:0] mul_a, mul_b;
   logic signed [37:0] prod28;

   always_comb begin
      addr_a  = AW'(32'(cnt_i) * RANK + 32'(cnt_r));
      addr_b  = AW'(32'(cnt_r) * DIM + 32'(cnt_i));
      load_ok = req_accept && (32'(req_index) < 32'(NENT));
      elem_ok = req_accept && (32'(req_index) < 32'(DIM)) &&
                ((req_kind == lrha_pkg::REQ_APPLY) || (req_kind == lrha_pkg::REQ_UPDATE));
      step    = cmd.exec;
      sum_ph  = (cmd.phase == lrha_pkg::PH_PROJ_B) || (cmd.phase == lrha_pkg::PH_PROJ_A) ||
                (cmd.phase == lrha_pkg::PH_OUT);
      gx      = lrha_pkg::sat32(48'(shift_ff));
      proj_r  = proj_ff[cnt_r];
      prod28  = 38'(prod_ff >>> 28);
      shift31 = (cmd.phase == lrha_pkg::PH_UPD_A) || (cmd.phase == lrha_pkg::PH_UPD_B) ||
                (cmd.phase == lrha_pkg::PH_DECAY_A) || (cmd.phase == lrha_pkg::PH_DECAY_B);
      shift_in = shift31 ? 38'(prod_ff >>> 31) : prod28;

      mul_a = 33'(gx);
      mul_b = 33'(rd_op_ff);
      if (cmd.sub == lrha_pkg::SUB_MUL1) begin
         case (cmd.phase)
            lrha_pkg::PH_PROJ_B:  begin mul_a = 33'(rd_b_ff); mul_b = 33'(rd_op_ff); end
            lrha_pkg::PH_PROJ_A:  begin mul_a = 33'(rd_a_ff); mul_b = 33'(rd_x_ff); end
            lrha_pkg::PH_UPD_A:   begin mul_a = $signed({2'b00, gain_ff}); mul_b = 33'(rd_x_ff); end
            lrha_pkg::PH_UPD_B:   begin mul_a = $signed({2'b00, gain_ff}); mul_b = 33'(proj_r); end
            lrha_pkg::PH_DECAY_A: begin mul_a = 33'(rd_a_ff); mul_b = $signed({1'b0, decay_ff}); end
            lrha_pkg::PH_DECAY_B: begin mul_a = 33'(rd_b_ff); mul_b = $signed({1'b0, decay_ff}); end
            default:              begin mul_a = 33'(rd_b_ff); mul_b = 33'(proj_r); end
         endcase
      end else if (cmd.phase == lrha_pkg::PH_UPD_A) begin
         mul_b = 33'(proj_r);
      end

      we_a = 1'b0;
      wa_a = addr_a;
      wd_a = '0;
      we_b = 1'b0;
      wa_b = addr_b;
      wd_b = '0;
      if (cmd.clr) begin
         we_a = 1'b1;
         we_b = 1'b1;
      end else if (load_ok && (req_kind == lrha_pkg::REQ_LOAD_A)) begin
         we_a = 1'b1;
         wa_a = AW'(req_index);
         wd_a = req_operand;
      end else if (load_ok && (req_kind == lrha_pkg::REQ_LOAD_B)) begin
         we_b = 1'b1;
         wa_b = AW'(req_index);
         wd_b = req_operand;
      end else if (step && (cmd.sub == lrha_pkg::SUB_WRITE)) begin
         case (cmd.phase)
            lrha_pkg::PH_UPD_A: begin
               we_a = 1'b1;
               wd_a = lrha_pkg::sat32(48'(rd_a_ff) + 48'(prod28));
            end
            lrha_pkg::PH_UPD_B: begin
               we_b = 1'b1;
               wd_b = lrha_pkg::sat32(48'(rd_b_ff) + 48'(prod28));
            end
            lrha_pkg::PH_DECAY_A: begin
               we_a = 1'b1;
               wd_a = gx;
            end
            lrha_pkg::PH_DECAY_B: begin
               we_b = 1'b1;
               wd_b = gx;
            end
            default: begin
               we_a = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (we_a) begin
         mem_a[wa_a] <= wd_a;
      end
      rd_a_ff <= mem_a[addr_a];
   end

   always_ff @(posedge clock) begin
      if (we_b) begin
         mem_b[wa_b] <= wd_b;
      end
      rd_b_ff <= mem_b[addr_b];
   end

   always_ff @(posedge clock) begin
      if (elem_ok) begin
         mem_x[IW'(req_index)]  <= req_x;
         mem_op[IW'(req_index)] <= req_operand;
      end
      rd_x_ff  <= mem_x[cnt_i];
      rd_op_ff <= mem_op[cnt_i];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff  <= lrha_pkg::GAIN_RST;
         decay_ff <= lrha_pkg::DECAY_RST;
      end else if (csr_we) begin
         case (csr_index)
            lrha_pkg::CSR_GAIN:  gain_ff  <= csr_wdata[30:0];
            lrha_pkg::CSR_DECAY: decay_ff <= csr_wdata;
            default:             gain_ff  <= gain_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (step && ((cmd.sub == lrha_pkg::SUB_MUL1) || (cmd.sub == lrha_pkg::SUB_MUL2))) begin
         prod_ff <= mul_a * mul_b;
      end
      if (step && (cmd.sub == lrha_pkg::SUB_SHIFT)) begin
         shift_ff <= shift_in;
      end
      if (!step && !cmd.fin) begin
         acc_ff <= '0;
      end else if (cmd.fin) begin
         acc_ff <= '0;
         if (cmd.phase == lrha_pkg::PH_OUT) begin
            out_value_ff <= lrha_pkg::sat32(48'(rd_op_ff) + 48'(lrha_pkg::sat32(acc_ff)));
            out_index_ff <= 6'(cnt_i);
            out_last_ff  <= (cnt_i == IW'(DIM - 1));
         end else begin
            proj_ff[cnt_r] <= lrha_pkg::sat32(acc_ff);
         end
      end else if (sum_ph && (cmd.sub == lrha_pkg::SUB_WRITE)) begin
         acc_ff <= acc_ff + 48'(shift_ff);
      end
   end

   assign status.decay_en = (decay_ff != '0) && !decay_ff[31];
   assign out_value = out_value_ff;
   assign out_index = out_index_ff;
   assign out_last  = out_last_ff;

endmodule

// ----- rtl/lrha_checker.sv -----
// Port-level checks of the adapter, bound to the top level.
// Depends on assert_macros.svh, lrha_pkg and the top level's ports.
`include "assert_macros.svh"
module lrha_checker #(
   parameter int DIM = lrha_pkg::DIM_DEF
) (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tlast
);

   `AM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))
   `AM_ASSERT_NOW(a_busy_emit, clock, reset, rsp_tvalid, !req_tready)
   `AM_ASSERT_NEXT(a_run_cont, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast, !req_tready)
   `AM_ASSERT_NOW(a_last_pos, clock, reset, rsp_tvalid && rsp_tlast,
                  rsp_tdata[37:32] == 6'(DIM - 1))

endmodule

bind low_rank_hebbian_adapter lrha_checker #(.DIM(DIM)) u_lrha_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

// ----- tb/low_rank_hebbian_adapter_tb.sv -----
// Self-checking bench for low_rank_hebbian_adapter: a table of directed beats,
// then random vectors under several gain and decay settings, checked against a
// behavioural predictor of the adapter. Depends on lrha_pkg and the RTL only.
module low_rank_hebbian_adapter_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lrha_pkg::*;

   localparam int DIM       = DIM_DEF;
   localparam int RANK      = RANK_DEF;
   localparam int ENTRIES   = DIM * RANK;
   localparam int WD_LIMIT  = 40000;
   localparam int SETTLE    = 8000;
   localparam int HOLD_LEN  = 2500;
   localparam logic [31:0] Q_ONE = 32'h1000_0000;
   localparam logic [31:0] S_MAX = 32'h7fff_ffff;
   localparam logic [31:0] S_MIN = 32'h8000_0000;

   typedef struct {
      logic [31:0] value;
      logic [5:0]  pos;
      logic        last;
   } out_beat_type;

   typedef struct {
      req_kind_type kind;
      logic [7:0]   idx;
      logic [31:0]  x;
      logic [31:0]  op;
      logic         last;
      bit           typed;
      logic [31:0]  first_out;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_GAIN;
   logic [31:0] csr_wdata = '0;

   low_rank_hebbian_adapter i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // predictor state
   int          mat_a [ENTRIES];
   int          mat_b [ENTRIES];
   int          x_slot [DIM];
   int          op_slot [DIM];
   int          proj [RANK];
   logic [30:0] gain_q  = GAIN_RST;
   logic [31:0] decay_q = DECAY_RST;

   out_beat_type pending_out [$];
   int          errors = 0;
   int          beats_in = 0;
   int          beats_out = 0;
   int          pace = 0;
   int          hold_reqs = 0;
   int          hold_seen = 0;
   int          hold_left = 0;
   int          idle_cyc = 0;

   function automatic int sat(longint v);
      if (v > 64'sd2147483647) return 32'h7fff_ffff;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return int'(v);
   endfunction

   function automatic longint qmul(int a, int b);
      return (longint'(a) * longint'(b)) >>> 28;
   endfunction

   function automatic int gain_scale(int v);
      longint g;
      g = longint'(gain_q);
      return sat((g * longint'(v)) >>> 31);
   endfunction

   function automatic void hebbian_update();
      longint s;
      longint d;
      int     p2 [RANK];
      int     gx;
      for (int r = 0; r < RANK; r++) begin
         s = 0;
         for (int i = 0; i < DIM; i++) s += qmul(mat_b[r*DIM+i], op_slot[i]);
         proj[r] = sat(s);
      end
      for (int i = 0; i < DIM; i++) begin
         gx = gain_scale(x_slot[i]);
         for (int r = 0; r < RANK; r++)
            mat_a[i*RANK+r] = sat(longint'(mat_a[i*RANK+r]) + qmul(gx, proj[r]));
      end
      for (int r = 0; r < RANK; r++) begin
         s = 0;
         for (int i = 0; i < DIM; i++) s += qmul(mat_a[i*RANK+r], x_slot[i]);
         p2[r] = sat(s);
         proj[r] = p2[r];
      end
      for (int r = 0; r < RANK; r++) begin
         gx = gain_scale(p2[r]);
         for (int i = 0; i < DIM; i++)
            mat_b[r*DIM+i] = sat(longint'(mat_b[r*DIM+i]) + qmul(gx, op_slot[i]));
      end
      if (decay_q > 0 && decay_q < 32'h8000_0000) begin
         d = longint'(decay_q);
         for (int k = 0; k < ENTRIES; k++) begin
            mat_a[k] = sat((longint'(mat_a[k]) * d) >>> 31);
            mat_b[k] = sat((longint'(mat_b[k]) * d) >>> 31);
         end
      end
   endfunction

   function automatic void adapter_apply();
      longint       s;
      out_beat_type e;
      for (int r = 0; r < RANK; r++) begin
         s = 0;
         for (int i = 0; i < DIM; i++) s += qmul(mat_a[i*RANK+r], x_slot[i]);
         proj[r] = sat(s);
      end
      for (int i = 0; i < DIM; i++) begin
         s = 0;
         for (int r = 0; r < RANK; r++) s += qmul(mat_b[r*DIM+i], proj[r]);
         e.value = sat(longint'(op_slot[i]) + longint'(sat(s)));
         e.pos   = i[5:0];
         e.last  = (i == DIM - 1);
         pending_out.push_back(e);
      end
   endfunction

   function automatic void adapter_step(req_kind_type k, logic [7:0] idx, logic [31:0] x,
                                        logic [31:0] op, logic last);
      if (k == REQ_LOAD_A || k == REQ_LOAD_B) begin
         if (idx < ENTRIES) begin
            if (k == REQ_LOAD_A) mat_a[idx] = op;
            else mat_b[idx] = op;
         end
      end else begin
         if (idx < DIM) begin
            x_slot[idx]  = x;
            op_slot[idx] = op;
         end
         if (last) begin
            if (k == REQ_APPLY) adapter_apply();
            else hebbian_update();
         end
      end
   endfunction

   function automatic logic [31:0] rand_word();
      int sel;
      sel = $urandom_range(7);
      case (sel)
         0: return S_MAX;
         1: return S_MIN;
         2, 3: return $urandom;
         default: return $urandom_range(32'h1fff_ffff) - 32'h1000_0000;
      endcase
   endfunction

   task automatic send_beat(req_kind_type k, logic [7:0] idx, logic [31:0] x,
                            logic [31:0] op, logic last);
      int idle_pct;
      idle_pct = (pace == 0) ? 19 : (pace == 1) ? 48 : 0;
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tdata  = {op, x, idx};
      req_tuser  = k;
      req_tlast  = last;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      adapter_step(k, idx, x, op, last);
      beats_in++;
      @(negedge clock);
   endtask

   task automatic drain(int extra);
      req_tvalid = 1'b0;
      while (pending_out.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [31:0] val);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we    = 1'b0;
      if (idx == CSR_GAIN) gain_q = val[30:0];
      else decay_q = val;
   endtask

   task automatic send_vector(req_kind_type k, int len, bit in_order);
      logic [7:0] idx;
      for (int n = 0; n < len; n++) begin
         idx = in_order ? 8'(n) : 8'($urandom_range(63));
         send_beat(k, idx, rand_word(), rand_word(), n == len - 1);
      end
   endtask

   task automatic random_items(int budget);
      int           start;
      int           sel;
      req_kind_type k;
      start = beats_in;
      while (beats_in - start < budget) begin
         sel = $urandom_range(9);
         k = $urandom_range(1) ? REQ_APPLY : REQ_UPDATE;
         if (sel < 3)
            send_beat($urandom_range(1) ? REQ_LOAD_B : REQ_LOAD_A, 8'($urandom),
                      rand_word(), rand_word(), 1'($urandom));
         else if (sel < 7)
            send_vector(k, $urandom_range(12, 1), 1'b0);
         else
            send_vector(k, DIM, 1'b1);
      end
   endtask

   // result side: ready pattern and long hold-off
   always @(negedge clock) begin
      if (hold_seen != hold_reqs) begin
         hold_seen = hold_reqs;
         hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready = 1'b0;
      end else if (pace == 0) begin
         rsp_tready = $urandom_range(99) >= 48;
      end else if (pace == 1) begin
         rsp_tready = $urandom_range(99) >= 19;
      end else begin
         rsp_tready = 1'b1;
      end
   end

   always @(posedge clock) begin
      out_beat_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         beats_out++;
         if (pending_out.size() == 0) begin
            $error("unexpected result beat, value %h", rsp_tdata[31:0]);
            errors++;
         end else begin
            e = pending_out.pop_front();
            if (rsp_tdata[31:0] !== e.value) begin
               $error("out_value expected %h actual %h", e.value, rsp_tdata[31:0]);
               errors++;
            end
            if (rsp_tdata[37:32] !== e.pos) begin
               $error("out_index expected %0d actual %0d", e.pos, rsp_tdata[37:32]);
               errors++;
            end
            if (rsp_tlast !== e.last) begin
               $error("out_last expected %b actual %b", e.last, rsp_tlast);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cyc = 0;
      end else begin
         idle_cyc++;
         if (idle_cyc >= WD_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", pending_out.size());
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin
      stim_row_type tbl [$];
      int          mark;
      logic [31:0] gains  [5];
      logic [31:0] decays [5];

      for (int k = 0; k < ENTRIES; k++) begin
         mat_a[k] = 0;
         mat_b[k] = 0;
      end
      for (int i = 0; i < DIM; i++) begin
         x_slot[i]  = 0;
         op_slot[i] = 0;
      end
      for (int r = 0; r < RANK; r++) proj[r] = 0;

      tbl.push_back('{REQ_APPLY,  8'd0,   S_MAX, S_MAX, 1'b1, 1'b1, S_MAX});
      tbl.push_back('{REQ_APPLY,  8'd0,   S_MIN, S_MIN, 1'b1, 1'b1, S_MIN});
      tbl.push_back('{REQ_APPLY,  8'd0,   Q_ONE, 32'd5, 1'b1, 1'b1, 32'd5});
      tbl.push_back('{REQ_LOAD_A, 8'd0,   '0, Q_ONE, 1'b0, 1'b0, '0});
      tbl.push_back('{REQ_LOAD_A, 8'd191, '1, S_MIN, 1'b1, 1'b0, '0});
      tbl.push_back('{REQ_LOAD_A, 8'd192, '0, S_MAX, 1'b0, 1'b0, '0});
      tbl.push_back('{REQ_LOAD_A, 8'd255, '1, S_MAX, 1'b1, 1'b0, '0});
      tbl.push_back('{REQ_LOAD_B, 8'd0,   '0, Q_ONE, 1'b0, 1'b0, '0});
      tbl.push_back('{REQ_LOAD_B, 8'd191, '0, S_MAX, 1'b0, 1'b0, '0});
      tbl.push_back('{REQ_LOAD_B, 8'd200, '0, S_MIN, 1'b0, 1'b0, '0});
      tbl.push_back('{REQ_APPLY,  8'd1,   Q_ONE, '0, 1'b0, 1'b0, '0});
      tbl.push_back('{REQ_APPLY,  8'd47,  S_MIN, S_MAX, 1'b1, 1'b0, '0});
      tbl.push_back('{REQ_APPLY,  8'd250, S_MAX, S_MAX, 1'b1, 1'b0, '0});
      tbl.push_back('{REQ_APPLY,  8'd48,  S_MIN, S_MIN, 1'b1, 1'b0, '0});
      tbl.push_back('{REQ_UPDATE, 8'd5,   Q_ONE, Q_ONE, 1'b1, 1'b0, '0});
      tbl.push_back('{REQ_UPDATE, 8'd47,  S_MAX, S_MIN, 1'b1, 1'b0, '0});
      tbl.push_back('{REQ_UPDATE, 8'd255, S_MIN, S_MAX, 1'b1, 1'b0, '0});
      tbl.push_back('{REQ_APPLY,  8'd0,   Q_ONE, S_MIN, 1'b1, 1'b0, '0});

      gains  = '{32'hffff_ffff, 32'h8000_0000, 32'h0000_0001, 32'h4000_0000, 32'h0001_0000};
      decays = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h7fff_ffff, 32'h7ff0_0000};

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // fill every element slot before anything reads them
      pace = 0;
      for (int i = 0; i < DIM; i++) send_beat(REQ_UPDATE, 8'(i), '0, '0, i == DIM - 1);
      for (int n = 0; n < tbl.size(); n++) begin
         send_beat(tbl[n].kind, tbl[n].idx, tbl[n].x, tbl[n].op, tbl[n].last);
         if (tbl[n].typed) pending_out[pending_out.size() - DIM].value = tbl[n].first_out;
      end

      for (int p = 0; p < 5; p++) begin
         drain(SETTLE);
         pace = (p < 2) ? 0 : (p < 4) ? 1 : 2;
         csr_write(CSR_GAIN, gains[p]);
         csr_write(CSR_DECAY, decays[p]);
         if (p == 1) begin
            hold_reqs++;
            send_vector(REQ_APPLY, DIM, 1'b1);
            send_vector(REQ_APPLY, 3, 1'b0);
         end
         random_items(8);
      end

      drain(SETTLE);
      $display("%0d request beats and %0d result beats over five gain/decay settings",
               beats_in, beats_out);
      $display("covered loads in and out of range, apply, update, decay on and off");
      if (errors == 0 && pending_out.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
